[sv/wfsg_pkg.sv]
// ----------------------------------------------------------------------------
// wfsg_pkg
// Shared types, codes and segment tables for the window frame span generator.
// ----------------------------------------------------------------------------
package wfsg_pkg;

  // row classes chosen by the front end
  localparam logic [2:0] CLS_MISS   = 3'd0;
  localparam logic [2:0] CLS_OUTER  = 3'd1;
  localparam logic [2:0] CLS_BEVEL1 = 3'd2;
  localparam logic [2:0] CLS_BEVEL2 = 3'd3;
  localparam logic [2:0] CLS_BEVEL3 = 3'd4;
  localparam logic [2:0] CLS_TITLE  = 3'd5;
  localparam logic [2:0] CLS_SEP    = 3'd6;
  localparam logic [2:0] CLS_AREA   = 3'd7;

  // segment anchors: both ends on the left edge, left to right, both on the right
  localparam logic [1:0] ANCHOR_LL = 2'd0;
  localparam logic [1:0] ANCHOR_LR = 2'd1;
  localparam logic [1:0] ANCHOR_RR = 2'd2;

  // colour slots
  localparam logic [1:0] COLOR_SHADOW = 2'd0;
  localparam logic [1:0] COLOR_LIGHT  = 2'd1;
  localparam logic [1:0] COLOR_MAIN   = 2'd2;
  localparam logic [1:0] COLOR_AREA   = 2'd3;

  // last row of the title band plus one
  localparam logic [12:0] TITLE_END = 13'd40;

  // register indexes on the configuration channel
  localparam logic [2:0] CFG_DISPLAY_WIDTH = 3'd0;
  localparam logic [2:0] CFG_SHADOW_COLOR  = 3'd1;
  localparam logic [2:0] CFG_AREA_COLOR    = 3'd2;
  localparam logic [2:0] CFG_LIGHT_UNFOC   = 3'd3;
  localparam logic [2:0] CFG_MAIN_UNFOC    = 3'd4;
  localparam logic [2:0] CFG_LIGHT_FOC     = 3'd5;
  localparam logic [2:0] CFG_MAIN_FOC      = 3'd6;

  // register reset values
  localparam logic [12:0] RST_DISPLAY_WIDTH = 13'd1920;
  localparam logic [31:0] RST_SHADOW_COLOR  = 32'hFF10_1010;
  localparam logic [31:0] RST_AREA_COLOR    = 32'hFF18_2838;
  localparam logic [31:0] RST_LIGHT_UNFOC   = 32'hFF68_7888;
  localparam logic [31:0] RST_MAIN_UNFOC    = 32'hFF48_5868;
  localparam logic [31:0] RST_LIGHT_FOC     = 32'hFF48_C888;
  localparam logic [31:0] RST_MAIN_FOC      = 32'hFF28_A868;

  // one segment of a row table
  typedef struct packed {
    logic [1:0]        anchor;
    logic signed [3:0] off0;
    logic signed [3:0] off1;
    logic [1:0]        color;
  } seg_t;

  // classified line request passed from front to back
  typedef struct packed {
    logic [2:0]         cls;
    logic               focused;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
  } line_req_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [12:0] display_width;
    logic [31:0] shadow;
    logic [31:0] area;
    logic [31:0] light_unfoc;
    logic [31:0] main_unfoc;
    logic [31:0] light_foc;
    logic [31:0] main_foc;
  } colors_t;

  function automatic seg_t mk_seg(input logic [1:0] anchor, input logic signed [3:0] off0,
                                  input logic signed [3:0] off1, input logic [1:0] color);
    seg_t s;
    s.anchor = anchor;
    s.off0   = off0;
    s.off1   = off1;
    s.color  = color;
    return s;
  endfunction

  // index of the final segment of each row class
  function automatic logic [3:0] seg_last(input logic [2:0] cls);
    logic [3:0] n;
    unique case (cls)
      CLS_BEVEL2: n = 4'd2;
      CLS_BEVEL3: n = 4'd4;
      CLS_TITLE:  n = 4'd4;
      CLS_SEP:    n = 4'd6;
      CLS_AREA:   n = 4'd8;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // segment tables
  function automatic seg_t seg_lookup(input logic [2:0] cls, input logic [3:0] idx);
    seg_t s;
    s = mk_seg(ANCHOR_LR, 4'sd0, 4'sd0, COLOR_SHADOW);
    unique case (cls)
      CLS_OUTER: s = mk_seg(ANCHOR_LR, 4'sd1, -4'sd1, COLOR_SHADOW);
      CLS_BEVEL2: begin
        unique case (idx)
          4'd0:    s = mk_seg(ANCHOR_LL, 4'sd0, 4'sd3, COLOR_SHADOW);
          4'd1:    s = mk_seg(ANCHOR_LR, 4'sd3, -4'sd3, COLOR_LIGHT);
          default: s = mk_seg(ANCHOR_RR, -4'sd3, 4'sd0, COLOR_SHADOW);
        endcase
      end
      CLS_BEVEL3: begin
        unique case (idx)
          4'd0:    s = mk_seg(ANCHOR_LL, 4'sd0, 4'sd2, COLOR_SHADOW);
          4'd1:    s = mk_seg(ANCHOR_LL, 4'sd2, 4'sd2, COLOR_LIGHT);
          4'd2:    s = mk_seg(ANCHOR_LR, 4'sd4, -4'sd4, COLOR_MAIN);
          4'd3:    s = mk_seg(ANCHOR_RR, -4'sd4, -4'sd2, COLOR_LIGHT);
          default: s = mk_seg(ANCHOR_RR, -4'sd2, 4'sd0, COLOR_SHADOW);
        endcase
      end
      CLS_TITLE: begin
        unique case (idx)
          4'd0:    s = mk_seg(ANCHOR_LL, 4'sd0, 4'sd2, COLOR_SHADOW);
          4'd1:    s = mk_seg(ANCHOR_LL, 4'sd2, 4'sd3, COLOR_LIGHT);
          4'd2:    s = mk_seg(ANCHOR_LR, 4'sd3, -4'sd3, COLOR_MAIN);
          4'd3:    s = mk_seg(ANCHOR_RR, -4'sd3, -4'sd2, COLOR_LIGHT);
          default: s = mk_seg(ANCHOR_RR, -4'sd2, 4'sd0, COLOR_SHADOW);
        endcase
      end
      CLS_SEP: begin
        unique case (idx)
          4'd0:    s = mk_seg(ANCHOR_LL, 4'sd0, 4'sd2, COLOR_SHADOW);
          4'd1:    s = mk_seg(ANCHOR_LL, 4'sd2, 4'sd3, COLOR_LIGHT);
          4'd2:    s = mk_seg(ANCHOR_LL, 4'sd3, 4'sd4, COLOR_MAIN);
          4'd3:    s = mk_seg(ANCHOR_LR, 4'sd4, -4'sd4, COLOR_SHADOW);
          4'd4:    s = mk_seg(ANCHOR_RR, -4'sd4, -4'sd3, COLOR_MAIN);
          4'd5:    s = mk_seg(ANCHOR_RR, -4'sd3, -4'sd2, COLOR_LIGHT);
          default: s = mk_seg(ANCHOR_RR, -4'sd2, 4'sd0, COLOR_SHADOW);
        endcase
      end
      CLS_AREA: begin
        unique case (idx)
          4'd0:    s = mk_seg(ANCHOR_LL, 4'sd0, 4'sd2, COLOR_SHADOW);
          4'd1:    s = mk_seg(ANCHOR_LL, 4'sd2, 4'sd3, COLOR_LIGHT);
          4'd2:    s = mk_seg(ANCHOR_LL, 4'sd3, 4'sd4, COLOR_MAIN);
          4'd3:    s = mk_seg(ANCHOR_LL, 4'sd4, 4'sd5, COLOR_SHADOW);
          4'd4:    s = mk_seg(ANCHOR_LR, 4'sd5, -4'sd5, COLOR_AREA);
          4'd5:    s = mk_seg(ANCHOR_RR, -4'sd5, -4'sd4, COLOR_SHADOW);
          4'd6:    s = mk_seg(ANCHOR_RR, -4'sd4, -4'sd3, COLOR_MAIN);
          4'd7:    s = mk_seg(ANCHOR_RR, -4'sd3, -4'sd2, COLOR_LIGHT);
          default: s = mk_seg(ANCHOR_RR, -4'sd2, 4'sd0, COLOR_SHADOW);
        endcase
      end
      default: s = mk_seg(ANCHOR_LR, 4'sd0, 4'sd0, COLOR_SHADOW);
    endcase
    return s;
  endfunction

endpackage

[sv/wfsg_front.sv]
// ----------------------------------------------------------------------------
// wfsg_front
// Takes line requests, runs the window hit test and picks the row class.
// ----------------------------------------------------------------------------
module wfsg_front (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,
  input  logic                 q_full,
  output logic                 push,
  output wfsg_pkg::line_req_t  req
);

  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] width;
  logic signed [15:0] height;
  logic signed [15:0] line_y;
  logic signed [15:0] top_end;
  logic signed [15:0] ly_full;
  logic signed [15:0] from_bottom_full;
  logic [12:0]        ly;
  logic [12:0]        from_bottom;
  logic               hit;

  // field unpacking, widened so nothing wraps
  assign left   = {{2{s_axis_tdata[13]}}, s_axis_tdata[13:0]};
  assign top    = {{2{s_axis_tdata[27]}}, s_axis_tdata[27:14]};
  assign width  = {3'b000, s_axis_tdata[40:28]};
  assign height = {3'b000, s_axis_tdata[53:41]};
  assign line_y = {4'b0000, s_axis_tdata[66:55]};

  // hit test and row offsets from the top and bottom
  assign top_end          = top + height;
  assign hit              = (line_y >= top) && (line_y < top_end);
  assign ly_full          = line_y - top;
  assign from_bottom_full = height - 16'sd1 - ly_full;
  assign ly               = ly_full[12:0];
  assign from_bottom      = from_bottom_full[12:0];

  // row class, outermost frame rows first, counted from the top or the bottom
  always_comb begin
    req.focused = s_axis_tdata[54];
    req.x0      = left;
    req.x1      = left + width;
    priority if (!hit)                               req.cls = wfsg_pkg::CLS_MISS;
    else if (ly == 13'd0 || from_bottom == 13'd0)    req.cls = wfsg_pkg::CLS_OUTER;
    else if (ly == 13'd1 || from_bottom == 13'd1)    req.cls = wfsg_pkg::CLS_BEVEL1;
    else if (ly == 13'd2 || from_bottom == 13'd2)    req.cls = wfsg_pkg::CLS_BEVEL2;
    else if (ly == 13'd3 || from_bottom == 13'd3)    req.cls = wfsg_pkg::CLS_BEVEL3;
    else if (ly < wfsg_pkg::TITLE_END)               req.cls = wfsg_pkg::CLS_TITLE;
    else if (ly == wfsg_pkg::TITLE_END)              req.cls = wfsg_pkg::CLS_SEP;
    else                                             req.cls = wfsg_pkg::CLS_AREA;
  end

  // handshake
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

endmodule

[sv/wfsg_queue.sv]
// ----------------------------------------------------------------------------
// wfsg_queue
// Small request queue between the classifier and the span emitter.
// ----------------------------------------------------------------------------
module wfsg_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wfsg_pkg::line_req_t  push_req,
  input  logic                 pop,
  output logic                 q_valid,
  output logic                 q_full,
  output wfsg_pkg::line_req_t  head
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  wfsg_pkg::line_req_t mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CntW'(DEPTH));
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/wfsg_back.sv]
// ----------------------------------------------------------------------------
// wfsg_back
// Walks the segment table of the queue head, one clamped span per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module wfsg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wfsg_pkg::colors_t    colors,
  input  logic                 q_valid,
  input  wfsg_pkg::line_req_t  head,
  output logic                 pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // span_start, span_end, span_color, zero pad
  output logic [0:0]           m_axis_tuser,   // span_empty
  output logic                 m_axis_tlast
);

  wfsg_pkg::seg_t     seg;
  logic [3:0]         idx;
  logic [3:0]         last_idx;
  logic               advance;
  logic               take;
  logic signed [15:0] end_a;
  logic signed [15:0] end_b;
  logic signed [16:0] p0;
  logic signed [16:0] p1;
  logic [12:0]        start_c;
  logic [12:0]        end_c;
  logic [31:0]        color;
  logic [12:0]        span_start;
  logic [12:0]        span_end;
  logic [31:0]        span_color;
  logic               span_empty;

  function automatic logic [12:0] clamp_x(input logic signed [16:0] p,
                                          input logic [12:0] dw);
    logic [12:0] r;
    if (p < 17'sd0) begin
      r = '0;
    end else if (p > $signed({4'b0000, dw})) begin
      r = dw;
    end else begin
      r = p[12:0];
    end
    return r;
  endfunction

  // current segment and its ends
  assign seg      = wfsg_pkg::seg_lookup(head.cls, idx);
  assign last_idx = wfsg_pkg::seg_last(head.cls);
  assign end_a    = (seg.anchor == wfsg_pkg::ANCHOR_RR) ? head.x1 : head.x0;
  assign end_b    = (seg.anchor == wfsg_pkg::ANCHOR_LL) ? head.x0 : head.x1;
  assign p0       = {end_a[15], end_a} + {{13{seg.off0[3]}}, seg.off0};
  assign p1       = {end_b[15], end_b} + {{13{seg.off1[3]}}, seg.off1};
  assign start_c  = clamp_x(p0, colors.display_width);
  assign end_c    = clamp_x(p1, colors.display_width);

  // colour slot to register
  always_comb begin
    unique case (seg.color)
      wfsg_pkg::COLOR_SHADOW: color = colors.shadow;
      wfsg_pkg::COLOR_LIGHT:  color = head.focused ? colors.light_foc : colors.light_unfoc;
      wfsg_pkg::COLOR_MAIN:   color = head.focused ? colors.main_foc : colors.main_unfoc;
      default:                color = colors.area;
    endcase
  end

  // output register handshake
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign take    = advance && q_valid;
  assign pop     = take && (idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else if (advance) begin
      m_axis_tvalid <= q_valid;
      if (take) begin
        idx <= pop ? 4'd0 : idx + 4'd1;
      end
    end
  end

  // span payload, a missed line gives one empty zero span
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tlast <= (idx == last_idx);
      if (head.cls == wfsg_pkg::CLS_MISS) begin
        span_start <= '0;
        span_end   <= '0;
        span_color <= '0;
        span_empty <= 1'b1;
      end else begin
        span_start <= start_c;
        span_end   <= end_c;
        span_color <= color;
        span_empty <= (start_c >= end_c);
      end
    end
  end

  assign m_axis_tdata = {6'b000000, span_color, span_end, span_start};
  assign m_axis_tuser = span_empty;

endmodule

[sv/window_frame_span_generator.sv]
// ----------------------------------------------------------------------------
// window_frame_span_generator
// Turns a window rectangle and a scanline into the frame colour spans.
// ----------------------------------------------------------------------------
// Line requests enter on the s_axis channel; spans leave on the m_axis
// channel, tlast marking the final span of a request and tuser flagging a
// span that draws nothing. A line that misses the window gives one empty
// span. The cfg channel writes display width and colours; it is always ready
// and should only be used while no request is in flight.
// Front end: hit test and row classification in the accept cycle, result
// pushed into a QUEUE_DEPTH-entry request queue. Back end: one span per cycle,
// while the receiver takes them, from the head's segment table into the
// output register. A request is registered in the queue, and its spans in
// the output register. Each request gives 1, 3, 5, 7 or 9 spans, the number
// of segments of its row class, from the single span emitter, which finishes
// one request before it takes the next; requests queue up meanwhile.
// When the receiver stalls the output register holds its span, the queue
// fills and s_axis_tready drops once it is full.
// Reset clears the queue and output valid and loads the default colours.
// ----------------------------------------------------------------------------
module window_frame_span_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // window_left, window_top, window_width,
                                      // window_height, focused, line_y, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // span_start, span_end, span_color, zero pad
  output logic [0:0]  m_axis_tuser,   // span_empty
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wfsg_pkg::colors_t   colors;
  wfsg_pkg::line_req_t push_req;
  wfsg_pkg::line_req_t head;
  logic                push;
  logic                pop;
  logic                q_valid;
  logic                q_full;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.display_width <= wfsg_pkg::RST_DISPLAY_WIDTH;
      colors.shadow        <= wfsg_pkg::RST_SHADOW_COLOR;
      colors.area          <= wfsg_pkg::RST_AREA_COLOR;
      colors.light_unfoc   <= wfsg_pkg::RST_LIGHT_UNFOC;
      colors.main_unfoc    <= wfsg_pkg::RST_MAIN_UNFOC;
      colors.light_foc     <= wfsg_pkg::RST_LIGHT_FOC;
      colors.main_foc      <= wfsg_pkg::RST_MAIN_FOC;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wfsg_pkg::CFG_DISPLAY_WIDTH: colors.display_width <= cfg_data[12:0];
        wfsg_pkg::CFG_SHADOW_COLOR:  colors.shadow        <= cfg_data;
        wfsg_pkg::CFG_AREA_COLOR:    colors.area          <= cfg_data;
        wfsg_pkg::CFG_LIGHT_UNFOC:   colors.light_unfoc   <= cfg_data;
        wfsg_pkg::CFG_MAIN_UNFOC:    colors.main_unfoc    <= cfg_data;
        wfsg_pkg::CFG_LIGHT_FOC:     colors.light_foc     <= cfg_data;
        wfsg_pkg::CFG_MAIN_FOC:      colors.main_foc      <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier
  wfsg_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .push          (push),
    .req           (push_req)
  );

  // request queue
  wfsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  // span emitter
  wfsg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .colors        (colors),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the window frame span generator.
// ----------------------------------------------------------------------------
// Line requests go in from a queue through a clocked driver. A clocked monitor
// predicts the frame spans of every accepted line from its own copy of the
// colour and width registers and checks each span that leaves the block, field
// by field, in order. A directed set covers every row class, window misses,
// zero height and clamping at both display edges. Random lines follow, mostly
// aimed at the frame rows, under six register settings that include a zero, a
// one-pixel and a maximum display width. Both sides idle in random bursts, the
// sink holds off once for a long stretch, and the last phase runs at full rate.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_CAP    = 100;

  // one line request, first field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [11:0] line_y;
    logic        focused;
    logic [12:0] height;
    logic [12:0] width;
    logic [13:0] top;
    logic [13:0] left;
  } line_req_t;

  // span data word as it leaves the block
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] color;
    logic [12:0] x_stop;
    logic [12:0] x_start;
  } span_word_t;

  // one expected span
  typedef struct packed {
    logic [12:0] x_start;
    logic [12:0] x_stop;
    logic [31:0] color;
    logic        empty;
    logic        last;
  } span_t;

  // one segment of a frame row
  typedef struct packed {
    logic [1:0] anchor;
    int         lo;
    int         hi;
    logic [1:0] slot;
  } frame_seg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  line_req_t   pending_lines [$];
  span_t       spans_due [$];
  logic [31:0] reg_value [0:6];
  logic        line_fire = 1'b0;
  bit          idle_on = 1'b0;
  int          src_gap = 0;
  int          stall_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          lines_taken = 0;
  int          spans_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  window_frame_span_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d spans outstanding", spans_due.size());
      $display("tb: errors");
      $finish;
    end
  end

  function automatic frame_seg_t seg(input logic [1:0] anchor, input int lo, input int hi,
                                     input logic [1:0] slot);
    frame_seg_t s;
    s.anchor = anchor;
    s.lo     = lo;
    s.hi     = hi;
    s.slot   = slot;
    return s;
  endfunction

  // number of spans of each row class
  function automatic int seg_total(input logic [2:0] cls);
    case (cls)
      wfsg_pkg::CLS_BEVEL2: return 3;
      wfsg_pkg::CLS_BEVEL3: return 5;
      wfsg_pkg::CLS_TITLE:  return 5;
      wfsg_pkg::CLS_SEP:    return 7;
      wfsg_pkg::CLS_AREA:   return 9;
      default:              return 1;
    endcase
  endfunction

  // row layouts, left to right
  function automatic frame_seg_t frame_seg(input logic [2:0] cls, input int idx);
    case (cls)
      wfsg_pkg::CLS_OUTER: return seg(wfsg_pkg::ANCHOR_LR, 1, -1, wfsg_pkg::COLOR_SHADOW);
      wfsg_pkg::CLS_BEVEL2: begin
        case (idx)
          0:       return seg(wfsg_pkg::ANCHOR_LL, 0, 3, wfsg_pkg::COLOR_SHADOW);
          1:       return seg(wfsg_pkg::ANCHOR_LR, 3, -3, wfsg_pkg::COLOR_LIGHT);
          default: return seg(wfsg_pkg::ANCHOR_RR, -3, 0, wfsg_pkg::COLOR_SHADOW);
        endcase
      end
      wfsg_pkg::CLS_BEVEL3: begin
        case (idx)
          0:       return seg(wfsg_pkg::ANCHOR_LL, 0, 2, wfsg_pkg::COLOR_SHADOW);
          1:       return seg(wfsg_pkg::ANCHOR_LL, 2, 2, wfsg_pkg::COLOR_LIGHT);
          2:       return seg(wfsg_pkg::ANCHOR_LR, 4, -4, wfsg_pkg::COLOR_MAIN);
          3:       return seg(wfsg_pkg::ANCHOR_RR, -4, -2, wfsg_pkg::COLOR_LIGHT);
          default: return seg(wfsg_pkg::ANCHOR_RR, -2, 0, wfsg_pkg::COLOR_SHADOW);
        endcase
      end
      wfsg_pkg::CLS_TITLE: begin
        case (idx)
          0:       return seg(wfsg_pkg::ANCHOR_LL, 0, 2, wfsg_pkg::COLOR_SHADOW);
          1:       return seg(wfsg_pkg::ANCHOR_LL, 2, 3, wfsg_pkg::COLOR_LIGHT);
          2:       return seg(wfsg_pkg::ANCHOR_LR, 3, -3, wfsg_pkg::COLOR_MAIN);
          3:       return seg(wfsg_pkg::ANCHOR_RR, -3, -2, wfsg_pkg::COLOR_LIGHT);
          default: return seg(wfsg_pkg::ANCHOR_RR, -2, 0, wfsg_pkg::COLOR_SHADOW);
        endcase
      end
      wfsg_pkg::CLS_SEP: begin
        case (idx)
          0:       return seg(wfsg_pkg::ANCHOR_LL, 0, 2, wfsg_pkg::COLOR_SHADOW);
          1:       return seg(wfsg_pkg::ANCHOR_LL, 2, 3, wfsg_pkg::COLOR_LIGHT);
          2:       return seg(wfsg_pkg::ANCHOR_LL, 3, 4, wfsg_pkg::COLOR_MAIN);
          3:       return seg(wfsg_pkg::ANCHOR_LR, 4, -4, wfsg_pkg::COLOR_SHADOW);
          4:       return seg(wfsg_pkg::ANCHOR_RR, -4, -3, wfsg_pkg::COLOR_MAIN);
          5:       return seg(wfsg_pkg::ANCHOR_RR, -3, -2, wfsg_pkg::COLOR_LIGHT);
          default: return seg(wfsg_pkg::ANCHOR_RR, -2, 0, wfsg_pkg::COLOR_SHADOW);
        endcase
      end
      wfsg_pkg::CLS_AREA: begin
        case (idx)
          0:       return seg(wfsg_pkg::ANCHOR_LL, 0, 2, wfsg_pkg::COLOR_SHADOW);
          1:       return seg(wfsg_pkg::ANCHOR_LL, 2, 3, wfsg_pkg::COLOR_LIGHT);
          2:       return seg(wfsg_pkg::ANCHOR_LL, 3, 4, wfsg_pkg::COLOR_MAIN);
          3:       return seg(wfsg_pkg::ANCHOR_LL, 4, 5, wfsg_pkg::COLOR_SHADOW);
          4:       return seg(wfsg_pkg::ANCHOR_LR, 5, -5, wfsg_pkg::COLOR_AREA);
          5:       return seg(wfsg_pkg::ANCHOR_RR, -5, -4, wfsg_pkg::COLOR_SHADOW);
          6:       return seg(wfsg_pkg::ANCHOR_RR, -4, -3, wfsg_pkg::COLOR_MAIN);
          7:       return seg(wfsg_pkg::ANCHOR_RR, -3, -2, wfsg_pkg::COLOR_LIGHT);
          default: return seg(wfsg_pkg::ANCHOR_RR, -2, 0, wfsg_pkg::COLOR_SHADOW);
        endcase
      end
      default: return seg(wfsg_pkg::ANCHOR_LR, 0, 0, wfsg_pkg::COLOR_SHADOW);
    endcase
  endfunction

  // clamp an x position to the visible line
  function automatic int clamp_x(input int x);
    int limit;
    limit = int'(reg_value[wfsg_pkg::CFG_DISPLAY_WIDTH][12:0]);
    if (x < 0) x = 0;
    if (x > limit) x = limit;
    return x;
  endfunction

  // expected spans of one line request
  task automatic predict_spans(input line_req_t r);
    int          left, top, w, h, y, ly, x0, x1, n, a, b, lo, hi, p0, p1;
    logic [2:0]  cls;
    logic [31:0] light, main;
    frame_seg_t  sg;
    span_t       s;
    left = {{18{r.left[13]}}, r.left};
    top  = {{18{r.top[13]}}, r.top};
    w    = int'(r.width);
    h    = int'(r.height);
    y    = int'(r.line_y);
    // line misses the window: one empty span
    if (!(y >= top && y < top + h)) begin
      s = '0;
      s.empty = 1'b1;
      s.last  = 1'b1;
      spans_due.push_back(s);
      return;
    end
    ly = y - top;
    // outer-row tests win, whether counted from the top or the bottom
    if (ly == 0 || ly == h - 1) cls = wfsg_pkg::CLS_OUTER;
    else if (ly == 1 || ly == h - 2) cls = wfsg_pkg::CLS_BEVEL1;
    else if (ly == 2 || ly == h - 3) cls = wfsg_pkg::CLS_BEVEL2;
    else if (ly == 3 || ly == h - 4) cls = wfsg_pkg::CLS_BEVEL3;
    else if (ly < int'(wfsg_pkg::TITLE_END)) cls = wfsg_pkg::CLS_TITLE;
    else if (ly == int'(wfsg_pkg::TITLE_END)) cls = wfsg_pkg::CLS_SEP;
    else cls = wfsg_pkg::CLS_AREA;
    light = r.focused ? reg_value[wfsg_pkg::CFG_LIGHT_FOC]
                      : reg_value[wfsg_pkg::CFG_LIGHT_UNFOC];
    main  = r.focused ? reg_value[wfsg_pkg::CFG_MAIN_FOC]
                      : reg_value[wfsg_pkg::CFG_MAIN_UNFOC];
    x0 = left;
    x1 = left + w;
    n  = seg_total(cls);
    for (int i = 0; i < n; i++) begin
      sg = frame_seg(cls, i);
      lo = sg.lo;
      hi = sg.hi;
      a  = (sg.anchor == wfsg_pkg::ANCHOR_RR) ? x1 : x0;
      b  = (sg.anchor == wfsg_pkg::ANCHOR_LL) ? x0 : x1;
      p0 = clamp_x(a + lo);
      p1 = clamp_x(b + hi);
      s.x_start = p0[12:0];
      s.x_stop  = p1[12:0];
      case (sg.slot)
        wfsg_pkg::COLOR_SHADOW: s.color = reg_value[wfsg_pkg::CFG_SHADOW_COLOR];
        wfsg_pkg::COLOR_LIGHT:  s.color = light;
        wfsg_pkg::COLOR_MAIN:   s.color = main;
        default:                s.color = reg_value[wfsg_pkg::CFG_AREA_COLOR];
      endcase
      s.empty = (p0 >= p1);
      s.last  = (i == n - 1);
      spans_due.push_back(s);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      // keep the log readable when everything goes wrong
      if (mismatches <= REPORT_CAP)
        $error("span %0d: %s expected %0h, got %0h", spans_seen, name, want, got);
    end
  endtask

  // accept side: prediction, then span checking
  always @(posedge clk) begin
    span_word_t word;
    span_t      want;
    line_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_spans(line_req_t'(s_axis_tdata));
      lines_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      word = span_word_t'(m_axis_tdata);
      if (spans_due.size() == 0) begin
        mismatches++;
        $error("span %0d arrived with no line request waiting", spans_seen);
      end else begin
        want = spans_due.pop_front();
        check_field("span_start", 32'(want.x_start), 32'(word.x_start));
        check_field("span_end", 32'(want.x_stop), 32'(word.x_stop));
        check_field("span_color", want.color, word.color);
        check_field("span_empty", 32'(want.empty), 32'(m_axis_tuser[0]));
        check_field("last_span", 32'(want.last), 32'(m_axis_tlast));
        check_field("tdata padding", '0, 32'(word.pad));
      end
      spans_seen++;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || line_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else if (pending_lines.size() != 0) begin
        s_axis_tdata  <= pending_lines.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // span sink with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic line_req_t line_at(input int left, input int top, input int w, input int h,
                                        input bit foc, input int y);
    line_req_t r;
    r = '0;
    r.left    = left[13:0];
    r.top     = top[13:0];
    r.width   = w[12:0];
    r.height  = h[12:0];
    r.focused = foc;
    r.line_y  = y[11:0];
    return r;
  endfunction

  // mostly lines that hit the frame rows, some fully random
  function automatic line_req_t random_line();
    int h, ly, y, w, left, hi_x;
    if ($urandom_range(0, 99) < 15) begin
      h = $urandom_range(1, 8191);
      return line_at($urandom, $urandom, $urandom_range(1, 8191), h, 1'($urandom), $urandom);
    end
    case ($urandom_range(0, 3))
      0:       h = $urandom_range(1, 12);
      1:       h = $urandom_range(41, 120);
      2:       h = $urandom_range(13, 400);
      default: h = $urandom_range(1, 8191);
    endcase
    case ($urandom_range(0, 3))
      0:       ly = $urandom_range(0, (h - 1 < 6) ? h - 1 : 6);
      1:       ly = h - 1 - $urandom_range(0, (h - 1 < 6) ? h - 1 : 6);
      2:       ly = $urandom_range(36, 44);
      default: ly = $urandom_range(0, h - 1);
    endcase
    if (ly > h - 1) ly = h - 1;
    y = $urandom_range(0, 4095);
    case ($urandom_range(0, 2))
      0:       w = $urandom_range(1, 12);
      1:       w = $urandom_range(13, 600);
      default: w = $urandom_range(1, 8191);
    endcase
    hi_x = int'(reg_value[wfsg_pkg::CFG_DISPLAY_WIDTH][12:0]) + 30;
    if (hi_x > 8191) hi_x = 8191;
    if ($urandom_range(0, 9) == 0) left = $urandom;
    else left = int'($urandom_range(0, hi_x + 30)) - 30;
    return line_at(left, y - ly, w, h, 1'($urandom), y);
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_lines.push_back(random_line());
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_value[idx] = (idx == wfsg_pkg::CFG_DISPLAY_WIDTH) ? {19'd0, val[12:0]} : val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // display width, then every colour from a fill value or at random
  task automatic program_regs(input logic [31:0] dw, input bit use_fill,
                              input logic [31:0] fill);
    write_reg(wfsg_pkg::CFG_DISPLAY_WIDTH, dw);
    for (int i = wfsg_pkg::CFG_SHADOW_COLOR; i <= wfsg_pkg::CFG_MAIN_FOC; i++)
      write_reg(i[2:0], use_fill ? fill : $urandom);
  endtask

  // hold back until every outstanding span has come out
  task automatic settle();
    while (pending_lines.size() != 0 || s_axis_tvalid || spans_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    int rows [12] = '{0, 1, 2, 3, 4, 39, 40, 41, 96, 97, 98, 99};
    reg_value[wfsg_pkg::CFG_DISPLAY_WIDTH] = {19'd0, wfsg_pkg::RST_DISPLAY_WIDTH};
    reg_value[wfsg_pkg::CFG_SHADOW_COLOR]  = wfsg_pkg::RST_SHADOW_COLOR;
    reg_value[wfsg_pkg::CFG_AREA_COLOR]    = wfsg_pkg::RST_AREA_COLOR;
    reg_value[wfsg_pkg::CFG_LIGHT_UNFOC]   = wfsg_pkg::RST_LIGHT_UNFOC;
    reg_value[wfsg_pkg::CFG_MAIN_UNFOC]    = wfsg_pkg::RST_MAIN_UNFOC;
    reg_value[wfsg_pkg::CFG_LIGHT_FOC]     = wfsg_pkg::RST_LIGHT_FOC;
    reg_value[wfsg_pkg::CFG_MAIN_FOC]      = wfsg_pkg::RST_MAIN_FOC;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // every row class of one window, focus alternating
    foreach (rows[i])
      pending_lines.push_back(line_at(100, 200, 300, 100, 1'(i % 2), 200 + rows[i]));
    // misses: above, one past the bottom, zero height, far negative and far positive tops
    pending_lines.push_back(line_at(10, 100, 50, 20, 0, 50));
    pending_lines.push_back(line_at(10, 0, 50, 10, 1, 10));
    pending_lines.push_back(line_at(10, 0, 50, 0, 0, 0));
    pending_lines.push_back(line_at(0, -8192, 8191, 8191, 1, 0));
    pending_lines.push_back(line_at(0, 8191, 10, 8191, 0, 4095));
    // negative top still hits, last scanline hits
    pending_lines.push_back(line_at(50, -100, 200, 200, 1, 50));
    pending_lines.push_back(line_at(0, 4000, 8191, 8191, 0, 4095));
    // clamping at both edges and narrow windows
    pending_lines.push_back(line_at(-8192, 0, 8191, 100, 1, 50));
    pending_lines.push_back(line_at(8191, 0, 8191, 100, 0, 50));
    pending_lines.push_back(line_at(-3, 0, 10, 100, 1, 60));
    pending_lines.push_back(line_at(1915, 0, 10, 100, 0, 40));
    pending_lines.push_back(line_at(20, 0, 1, 100, 1, 70));
    // tiny heights fold the top and bottom rows together
    pending_lines.push_back(line_at(5, 7, 30, 1, 0, 7));
    pending_lines.push_back(line_at(5, 7, 30, 2, 1, 8));
    pending_lines.push_back(line_at(5, 7, 30, 5, 0, 9));

    // long sink hold-off while the driver keeps offering lines
    hold_requests++;
    queue_random(60);
    settle();

    // widest normal display, random colours
    program_regs(32'd4096, 1'b0, '0);
    queue_random(75);
    settle();

    // one pixel wide display, black palette
    program_regs(32'd1, 1'b1, 32'h0000_0000);
    queue_random(60);
    settle();

    // zero width: every span empty; all-ones palette
    program_regs(32'd0, 1'b1, 32'hFFFF_FFFF);
    queue_random(50);
    settle();

    // upper bits of the width write are dropped, leaving the largest clamp
    program_regs(32'hFFFF_FFFF, 1'b0, '0);
    queue_random(60);
    settle();

    // ordinary width, no idling on either side
    program_regs(32'd640, 1'b0, '0);
    idle_on = 1'b0;
    queue_random(140);
    settle();

    $display("summary: %0d line requests and %0d spans checked under six register settings",
             lines_taken, spans_seen);
    $display("summary: %0d field mismatches", mismatches);
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
